/* rtl/hrdr_pkg.sv */
// Shared types and constants of the HyperRAM device responder.
// No dependencies; used by hrdr_store and hyperram_device_responder_top.
package hrdr_pkg;

   typedef enum logic [1:0] {
      EDGE_NONE = 2'd0,
      EDGE_RISE = 2'd1,
      EDGE_FALL = 2'd2
   } edge_code_type;

   localparam int unsigned SEL_BITS      = 2;
   localparam int unsigned CA_BYTES      = 6;
   localparam int unsigned CA_BITS       = 48;
   localparam int unsigned CA_READ_BIT   = 47;
   localparam logic [7:0]  ADDR_EDGE     = 8'd6;
   localparam logic [7:0]  DATA_EDGE_MIN = 8'd7;
   localparam logic [7:0]  EDGE_CNT_MAX  = 8'd255;
   localparam logic [3:0]  LATENCY_RESET = 4'd7;

   typedef struct packed {
      logic rd_en;
      logic wr_en;
   } store_ctl_type;

   // index of the first data edge, computed from the latency setting
   function automatic logic [6:0] data_start(input logic [3:0] lat);
      return {1'b0, lat, 2'b00} + 7'd4;
   endfunction

endpackage

/* rtl/hrdr_store.sv */
// Byte store of the responder: single-port synchronous RAM with registered read
// and a clearing pass after reset. Depends on hrdr_pkg.
module hrdr_store #(
   parameter int unsigned DEPTH = 131072,
   parameter int unsigned AW    = 17
) (
   input  logic                   clock,
   input  logic                   reset,
   input  hrdr_pkg::store_ctl_type ctl,
   input  logic [AW-1:0]          addr,
   input  logic [7:0]             wdata,
   output logic [7:0]             rdata,
   output logic                   ready
);

   logic [7:0]    mem [DEPTH];
   logic [7:0]    rdata_ff;
   logic          clear_ff;
   logic          clear_in;
   logic [AW-1:0] clr_addr_ff;
   logic [AW-1:0] clr_addr_in;
   logic          clr_last;

   assign clr_last = clr_addr_ff == AW'(DEPTH - 1);

   always_comb begin
      clear_in    = clear_ff;
      clr_addr_in = clr_addr_ff;
      if (clear_ff) begin
         clr_addr_in = clr_addr_ff + 1'b1;
         if (clr_last) begin
            clear_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ff    <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         clear_ff    <= clear_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (clear_ff) begin
         mem[clr_addr_ff] <= '0;
      end else if (ctl.wr_en) begin
         mem[addr] <= wdata;
      end
      if (ctl.rd_en) begin
         rdata_ff <= mem[addr];
      end
   end

   assign rdata = rdata_ff;
   assign ready = !clear_ff;

   a_no_access_in_clear: assert property (@(posedge clock) disable iff (reset)
      clear_ff |-> !ctl.rd_en && !ctl.wr_en)
      else $error("store accessed during clearing pass");

   a_single_port: assert property (@(posedge clock) disable iff (reset)
      !(ctl.rd_en && ctl.wr_en))
      else $error("store read and written in one cycle");

   a_clear_runs: assert property (@(posedge clock) disable iff (reset)
      clear_ff && !clr_last |=> clear_ff)
      else $error("clearing pass ended early");

endmodule

/* rtl/hyperram_device_responder_top.sv */
// HyperRAM device responder, top level: select tracking, command capture,
// data phase control and output stages. Depends on hrdr_pkg, hrdr_store.
//
//  channel  dir  handshake              payload
//  csr      in   csr_valid/csr_ready    csr_data  latency_clocks
//  req      in   req_tvalid/req_tready  req_tdata link sample
//  rsp      out  rsp_tvalid/rsp_tready  rsp_tdata read byte, strobe, driven
//
// One request transfer per cycle while req_tready is high; its response passes
// the store read stage, then the output register, one response per request.
// After reset the store is cleared one byte a cycle: req_tready stays low
// until all NUM_DEVICES * 2**DEVICE_ADDR_BITS bytes (131072 at defaults) are cleared.
// Back-pressure on rsp fills the output register and the read stage, then
// holds req_tready low. csr is always ready.
module hyperram_device_responder_top #(
   parameter int unsigned NUM_DEVICES      = 2,
   parameter int unsigned DEVICE_ADDR_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [3:0]  csr_data,    // latency_clocks
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // chip_select_n[1:0], clock_edge[3:2],
                                    // write_byte[11:4], write_mask[12]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata    // read_byte[7:0], read_strobe[8],
                                    // read_driven[9]
);

   localparam int unsigned STORE_DEPTH = NUM_DEVICES << DEVICE_ADDR_BITS;
   localparam int unsigned AW          = $clog2(STORE_DEPTH);
   localparam int unsigned DAB         = DEVICE_ADDR_BITS;
   localparam int unsigned SB          = hrdr_pkg::SEL_BITS;

   logic [SB-1:0]  sel;
   logic [1:0]     edge_code;
   logic [7:0]     dq;
   logic           mask;

   logic [3:0]     lat_ff, lat_in;
   logic [SB-1:0]  dev_ff, dev_in;
   logic           dev_valid_ff, dev_valid_in;
   logic [7:0]     ec_ff, ec_in;
   logic [SB-1:0]  last_sel_ff, last_sel_in;
   logic [hrdr_pkg::CA_BITS-1:0] ca_ff, ca_in;
   logic [AW-1:0]  addr_ff, addr_in;

   logic           req_fire;
   logic           sel_change;
   logic [SB-1:0]  pick_dev;
   logic           pick_valid;
   logic [SB-1:0]  cur_dev;
   logic           cur_valid;
   logic [7:0]     cur_ec;
   logic [hrdr_pkg::CA_BITS-1:0] cur_ca;
   logic           is_edge;
   logic           is_rise;
   logic           data_phase;
   logic           is_read;
   logic [27:0]    word2;
   logic [DAB+SB-1:0] full_addr;

   hrdr_pkg::store_ctl_type store_ctl;
   logic [7:0]     store_rdata;
   logic           store_ready;

   logic           s1_valid_ff, s1_valid_in;
   logic           s1_read_ff, s1_strobe_ff;
   logic           s1_move;
   logic           out_free;
   logic           out_valid_ff, out_valid_in;
   logic [7:0]     out_byte_ff, out_byte_in;
   logic           out_strobe_ff, out_strobe_in;
   logic           out_driven_ff;
   logic [7:0]     held_byte_ff;
   logic           held_strobe_ff;

   assign sel       = req_tdata[1:0];
   assign edge_code = req_tdata[3:2];
   assign dq        = req_tdata[11:4];
   assign mask      = req_tdata[12];

   assign csr_ready  = 1'b1;
   assign out_free   = !out_valid_ff || rsp_tready;
   assign s1_move    = s1_valid_ff && out_free;
   assign req_tready = store_ready && (!s1_valid_ff || out_free);
   assign req_fire   = req_tvalid && req_tready;

   // highest low select wins
   always_comb begin
      pick_dev   = '0;
      pick_valid = 1'b0;
      for (int i = 0; i < SB; i++) begin
         if (i < NUM_DEVICES && !sel[i]) begin
            pick_dev   = SB'(i);
            pick_valid = 1'b1;
         end
      end
   end

   assign sel_change = sel != last_sel_ff;
   assign cur_dev    = sel_change ? pick_dev : dev_ff;
   assign cur_valid  = sel_change ? pick_valid : dev_valid_ff;
   assign cur_ec     = sel_change ? 8'd0 : ec_ff;
   assign cur_ca     = sel_change ? '0 : ca_ff;

   assign is_rise = edge_code == hrdr_pkg::EDGE_RISE;
   assign is_edge = cur_valid && (is_rise || edge_code == hrdr_pkg::EDGE_FALL);
   assign data_phase = cur_ec >= hrdr_pkg::DATA_EDGE_MIN &&
                       cur_ec >= {1'b0, hrdr_pkg::data_start(lat_ff)};
   assign is_read = cur_ca[hrdr_pkg::CA_READ_BIT];

   assign word2     = {cur_ca[39:16], cur_ca[2:0], 1'b0};
   assign full_addr = {cur_dev, word2[DAB-1:0]};

   always_comb begin
      lat_in       = csr_valid ? csr_data : lat_ff;
      dev_in       = dev_ff;
      dev_valid_in = dev_valid_ff;
      ec_in        = ec_ff;
      last_sel_in  = last_sel_ff;
      ca_in        = ca_ff;
      addr_in      = addr_ff;
      store_ctl    = '0;
      if (req_fire) begin
         dev_in       = cur_dev;
         dev_valid_in = cur_valid;
         last_sel_in  = sel;
         ca_in        = cur_ca;
         ec_in        = cur_ec;
         if (is_edge) begin
            for (int b = 0; b < hrdr_pkg::CA_BYTES; b++) begin
               if (cur_ec == 8'(hrdr_pkg::CA_BYTES - 1 - b)) begin
                  ca_in[b*8 +: 8] = cur_ca[b*8 +: 8] | dq;
               end
            end
            if (cur_ec == hrdr_pkg::ADDR_EDGE) begin
               addr_in = AW'(full_addr);
            end else if (data_phase) begin
               store_ctl.rd_en = is_read;
               store_ctl.wr_en = !is_read && !mask;
               addr_in = (addr_ff == AW'(STORE_DEPTH - 1)) ? '0 : addr_ff + 1'b1;
            end
            if (cur_ec != hrdr_pkg::EDGE_CNT_MAX) begin
               ec_in = cur_ec + 8'd1;
            end
         end
      end
   end

   hrdr_store #(
      .DEPTH (STORE_DEPTH),
      .AW    (AW)
   ) u_store (
      .clock (clock),
      .reset (reset),
      .ctl   (store_ctl),
      .addr  (addr_ff),
      .wdata (dq),
      .rdata (store_rdata),
      .ready (store_ready)
   );

   assign s1_valid_in   = req_fire ? 1'b1 : (s1_move ? 1'b0 : s1_valid_ff);
   assign out_valid_in  = s1_move ? 1'b1 : (rsp_tready ? 1'b0 : out_valid_ff);
   assign out_byte_in   = s1_read_ff ? store_rdata : held_byte_ff;
   assign out_strobe_in = s1_read_ff ? s1_strobe_ff : held_strobe_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         lat_ff         <= hrdr_pkg::LATENCY_RESET;
         dev_ff         <= '0;
         dev_valid_ff   <= 1'b0;
         ec_ff          <= '0;
         last_sel_ff    <= '0;
         ca_ff          <= '0;
         addr_ff        <= '0;
         s1_valid_ff    <= 1'b0;
         out_valid_ff   <= 1'b0;
         held_byte_ff   <= '0;
         held_strobe_ff <= 1'b0;
      end else begin
         lat_ff       <= lat_in;
         dev_ff       <= dev_in;
         dev_valid_ff <= dev_valid_in;
         ec_ff        <= ec_in;
         last_sel_ff  <= last_sel_in;
         ca_ff        <= ca_in;
         addr_ff      <= addr_in;
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         if (s1_move) begin
            held_byte_ff   <= out_byte_in;
            held_strobe_ff <= out_strobe_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_read_ff   <= store_ctl.rd_en;
         s1_strobe_ff <= is_rise;
      end
      if (s1_move) begin
         out_byte_ff   <= out_byte_in;
         out_strobe_ff <= out_strobe_in;
         out_driven_ff <= s1_read_ff;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {6'b0, out_driven_ff, out_strobe_ff, out_byte_ff};

   a_no_req_in_clear: assert property (@(posedge clock) disable iff (reset)
      !store_ready |-> !req_tready)
      else $error("request taken during store clear");

   a_restart_count: assert property (@(posedge clock) disable iff (reset)
      req_fire && sel_change |=> ec_ff <= 8'd1)
      else $error("edge count not restarted on select change");

   a_count_saturates: assert property (@(posedge clock) disable iff (reset)
      req_fire && !sel_change && ec_ff == hrdr_pkg::EDGE_CNT_MAX |=>
      ec_ff == hrdr_pkg::EDGE_CNT_MAX)
      else $error("edge count wrapped");

   a_held_tracks_read: assert property (@(posedge clock) disable iff (reset)
      s1_move && s1_read_ff |=> out_driven_ff && held_byte_ff == out_byte_ff)
      else $error("held read byte out of step with response");

endmodule
